/* src/mrf_pkg.sv */
// ----------------------------------------------------------------------------
// mrf_pkg: shared types and codes of the mesh relay forwarder
// Holds command and status codes and the queue entry type between front and back.
// ----------------------------------------------------------------------------
package mrf_pkg;

  localparam logic [2:0] CMD_FORWARD = 3'd0;
  localparam logic [2:0] CMD_RELAY   = 3'd1;
  localparam logic [2:0] CMD_LEARN   = 3'd2;
  localparam logic [2:0] CMD_FORGET  = 3'd3;
  localparam logic [2:0] CMD_PURGE   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FOR_ME    = 3'd1;
  localparam logic [2:0] ST_OWN       = 3'd2;
  localparam logic [2:0] ST_HOP_LIMIT = 3'd3;
  localparam logic [2:0] ST_DUPLICATE = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic [1:0] REG_SELF  = 2'd0;
  localparam logic [1:0] REG_BCAST = 2'd1;
  localparam logic [1:0] REG_MASK  = 2'd2;
  localparam logic [1:0] REG_EXP   = 2'd3;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [2:0]  command;
    logic        early;     // decided in the front, no table work
    logic [2:0]  status;
    logic [63:0] sender;
    logic [63:0] receiver;
    logic [39:0] type_seq;
    logic [7:0]  ttl;
    logic [7:0]  flags;
    logic [63:0] via_node;
    logic [31:0] now_tick;
  } item_t;

endpackage

/* src/mrf_front.sv */
// ----------------------------------------------------------------------------
// mrf_front: input stage
// Accepts headers, runs the address and hop checks and pushes a classified item.
// ----------------------------------------------------------------------------
module mrf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       command_i,
  input  logic [63:0]      sender_i,
  input  logic [63:0]      receiver_i,
  input  logic [7:0]       frame_type_i,
  input  logic [31:0]      sequence_req_i,
  input  logic [7:0]       ttl_i,
  input  logic [7:0]       flags_i,
  input  logic [63:0]      via_node_i,
  input  logic [31:0]      now_tick_i,
  input  logic [63:0]      self_addr_i,
  input  logic [63:0]      bcast_addr_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output mrf_pkg::item_t   q_item_o
);

  logic           valid_q, valid_d;
  mrf_pkg::item_t item_q, item_d;

  assign in_ready_o = !valid_q || q_ready_i;
  assign q_valid_o  = valid_q;
  assign q_item_o   = item_q;

  always_comb begin
    logic fw;
    fw = (command_i == mrf_pkg::CMD_FORWARD);
    item_d          = '0;
    item_d.command  = command_i;
    item_d.sender   = sender_i;
    item_d.receiver = receiver_i;
    item_d.type_seq = {frame_type_i, sequence_req_i};
    item_d.ttl      = ttl_i;
    item_d.flags    = flags_i;
    item_d.via_node = via_node_i;
    item_d.now_tick = now_tick_i;
    item_d.status   = mrf_pkg::ST_OK;
    if (fw || command_i == mrf_pkg::CMD_RELAY) begin
      if (fw && (receiver_i == self_addr_i || receiver_i == bcast_addr_i)) begin
        item_d.early  = 1'b1;
        item_d.status = mrf_pkg::ST_FOR_ME;
      end else if (sender_i == self_addr_i) begin
        item_d.early  = 1'b1;
        item_d.status = mrf_pkg::ST_OWN;
      end else if (ttl_i <= 8'd1) begin
        item_d.early  = 1'b1;
        item_d.status = mrf_pkg::ST_HOP_LIMIT;
      end
    end else if (command_i > mrf_pkg::CMD_PURGE) begin
      item_d.early = 1'b1;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) valid_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) item_q <= item_d;
  end

endmodule

/* src/mrf_back.sv */
// ----------------------------------------------------------------------------
// mrf_back: table engine
// Walks the seen cache and the route table one entry a cycle and builds results.
// ----------------------------------------------------------------------------
module mrf_back #(
  parameter int ROUTE_ENTRIES = 16,
  parameter int SEEN_ENTRIES  = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  mrf_pkg::item_t q_item_i,
  input  logic [7:0]     mask_i,
  input  logic [31:0]    expiry_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           relay_o,
  output logic           flood_o,
  output logic [63:0]    hop_addr_o,
  output logic [7:0]     out_ttl_o,
  output logic [7:0]     out_flags_o,
  output logic [2:0]     status_o,
  output logic [4:0]     purged_count_o
);

  localparam int RW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int SW = (SEEN_ENTRIES > 1) ? $clog2(SEEN_ENTRIES) : 1;
  localparam logic [RW:0] RLAST = (RW+1)'(ROUTE_ENTRIES - 1);
  localparam logic [SW:0] SLAST = (SW+1)'(SEEN_ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEEN  = 3'd1;
  localparam logic [2:0] S_ROUTE = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_q, state_d;
  mrf_pkg::item_t it_q;

  // Route table: valid bits in flops, payload in flops read at the walk counter or the hit index.
  logic [ROUTE_ENTRIES-1:0] rvalid_q;
  logic [63:0] rdst_q [ROUTE_ENTRIES];
  logic [63:0] rvia_q [ROUTE_ENTRIES];
  logic [31:0] rlast_q [ROUTE_ENTRIES];
  // Seen cache: memory with registered read.
  logic [SEEN_ENTRIES-1:0] svalid_q;
  logic [103:0] smem [SEEN_ENTRIES];
  logic [103:0] srd_q;
  logic         srd_v_q;
  logic [SW-1:0] wpos_q;

  logic [SW:0] sidx_q;   // read address counter
  logic [RW:0] ridx_q;
  logic        hit_q, found_q, free_q;
  logic [RW-1:0] hit_i_q, free_i_q;
  logic [4:0]  cnt_q;

  logic        ovalid_q;
  logic        relay_q, flood_q;
  logic [63:0] hop_q;
  logic [7:0]  ttlo_q, flo_q;
  logic [2:0]  st_q;
  logic [4:0]  pc_q;

  assign q_ready_o   = (state_q == S_IDLE) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign relay_o = relay_q;  assign flood_o = flood_q;  assign hop_addr_o = hop_q;
  assign out_ttl_o = ttlo_q; assign out_flags_o = flo_q; assign status_o = st_q;
  assign purged_count_o = pc_q;

  logic [RW-1:0] ri;
  logic          rmatch;
  logic [31:0]   age;
  logic          is_frame;
  assign ri       = ridx_q[RW-1:0];
  assign rmatch   = rvalid_q[ri] && rdst_q[ri] == it_q.receiver;
  assign age      = it_q.now_tick - rlast_q[ri];
  assign is_frame = it_q.command == mrf_pkg::CMD_FORWARD || it_q.command == mrf_pkg::CMD_RELAY;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (q_valid_i && q_ready_o) state_d = q_item_i.early ? S_OUT :
                 ((q_item_i.command == mrf_pkg::CMD_FORWARD ||
                   q_item_i.command == mrf_pkg::CMD_RELAY) ? S_SEEN : S_ROUTE);
      S_SEEN:  if (srd_v_q && svalid_q[sidx_q[SW-1:0] - SW'(1)] &&
                   srd_q == {it_q.sender, it_q.type_seq}) state_d = S_OUT;
               else if (sidx_q == SLAST + 1'b1 && !srd_v_q) state_d = S_ROUTE;
               else if (sidx_q > SLAST && srd_v_q) state_d = S_SEEN;
      S_ROUTE: if (ridx_q == RLAST) state_d = S_WRITE;
      S_WRITE: state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      rvalid_q <= '0;
      svalid_q <= '0;
      wpos_q   <= '0;
      srd_v_q  <= 1'b0;
      sidx_q   <= '0;
      ridx_q   <= '0;
      hit_q    <= 1'b0;
      found_q  <= 1'b0;
      free_q   <= 1'b0;
      hit_i_q  <= '0;
      free_i_q <= '0;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          sidx_q <= '0; ridx_q <= '0; srd_v_q <= 1'b0;
          hit_q <= 1'b0; found_q <= 1'b0; free_q <= 1'b0; cnt_q <= '0;
        end
        S_SEEN: begin
          if (sidx_q <= SLAST) begin
            sidx_q  <= sidx_q + 1'b1;
            srd_v_q <= 1'b1;
          end else begin
            srd_v_q <= 1'b0;
          end
          if (srd_v_q && svalid_q[sidx_q[SW-1:0] - SW'(1)] &&
              srd_q == {it_q.sender, it_q.type_seq}) hit_q <= 1'b1;
        end
        S_ROUTE: begin
          ridx_q <= ridx_q + 1'b1;
          if (rmatch && !found_q) begin
            found_q <= 1'b1; hit_i_q <= ri;
          end
          if (!rvalid_q[ri] && !free_q) begin
            free_q <= 1'b1; free_i_q <= ri;
          end
          if (it_q.command == mrf_pkg::CMD_PURGE && rvalid_q[ri] && age > expiry_i) begin
            rvalid_q[ri] <= 1'b0;
            if (cnt_q != 5'd31) cnt_q <= cnt_q + 5'd1;
          end
        end
        S_WRITE: begin
          if (it_q.command == mrf_pkg::CMD_LEARN) begin
            if (found_q || free_q) rvalid_q[found_q ? hit_i_q : free_i_q] <= 1'b1;
          end else if (it_q.command == mrf_pkg::CMD_FORGET && found_q) begin
            rvalid_q[hit_i_q] <= 1'b0;
          end
        end
        S_OUT: begin
          ovalid_q <= 1'b1;
          if (is_frame && !it_q.early && !hit_q) begin
            svalid_q[wpos_q] <= 1'b1;
            wpos_q <= (wpos_q == SLAST[SW-1:0]) ? '0 : wpos_q + SW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload side: item capture, memories and result fields.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i && q_ready_o) it_q <= q_item_i;
    if (state_q == S_SEEN && sidx_q <= SLAST) srd_q <= smem[sidx_q[SW-1:0]];
    if (state_q == S_OUT && is_frame && !it_q.early && !hit_q)
      smem[wpos_q] <= {it_q.sender, it_q.type_seq};
    if (state_q == S_WRITE && it_q.command == mrf_pkg::CMD_LEARN && (found_q || free_q)) begin
      rdst_q[found_q ? hit_i_q : free_i_q]  <= it_q.receiver;
      rvia_q[found_q ? hit_i_q : free_i_q]  <= it_q.via_node;
      rlast_q[found_q ? hit_i_q : free_i_q] <= it_q.now_tick;
    end
    if (state_q == S_OUT) begin
      relay_q <= 1'b0; flood_q <= 1'b0; hop_q <= '0; ttlo_q <= '0; flo_q <= '0;
      pc_q <= '0; st_q <= it_q.status;
      if (is_frame && !it_q.early) begin
        if (hit_q) begin
          st_q <= mrf_pkg::ST_DUPLICATE;
        end else begin
          relay_q <= 1'b1;
          ttlo_q  <= it_q.ttl - 8'd1;
          flo_q   <= it_q.flags | mask_i;
          if (it_q.command == mrf_pkg::CMD_FORWARD && found_q) hop_q <= rvia_q[hit_i_q];
          else flood_q <= 1'b1;
        end
      end else if (it_q.command == mrf_pkg::CMD_LEARN && !it_q.early) begin
        if (!found_q && !free_q) st_q <= mrf_pkg::ST_FULL;
      end else if (it_q.command == mrf_pkg::CMD_PURGE) begin
        pc_q <= cnt_q;
      end
    end
  end

endmodule

/* src/mesh_relay_forwarder_top.sv */
// ----------------------------------------------------------------------------
// mesh_relay_forwarder_top: mesh relay decision engine
// Front stage checks header addresses; back engine walks seen cache and routes.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Beat content
//  in       input      in_valid_i / in_ready_o    command and header fields
//  cfg      input      cfg_valid_i / cfg_ready_o  register index and data
//  out      output     out_valid_o / out_ready_i  relay decision and status
//
// A frame item walks the seen cache, one entry a cycle, then the route table,
// and its result follows; a duplicate ends the walk at the matching entry.
// Table commands walk only the route table, and items decided by the front
// stage skip both walks.
// The front register holds one beat while the back engine works.
// Reset clears all valid bits at once, so no clearing pass is needed.
// An unaccepted result stalls the back engine; the front stalls behind it.
module mesh_relay_forwarder_top #(
  parameter int ROUTE_ENTRIES = 16,
  parameter int SEEN_ENTRIES  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] sender_i,
  input  logic [63:0] receiver_i,
  input  logic [7:0]  frame_type_i,
  input  logic [31:0] sequence_req_i,
  input  logic [7:0]  ttl_i,
  input  logic [7:0]  flags_i,
  input  logic [63:0] via_node_i,
  input  logic [31:0] now_tick_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        relay_o,
  output logic        flood_o,
  output logic [63:0] hop_addr_o,
  output logic [7:0]  out_ttl_o,
  output logic [7:0]  out_flags_o,
  output logic [2:0]  status_o,
  output logic [4:0]  purged_count_o
);

  logic [63:0] self_q, bcast_q;
  logic [7:0]  mask_q;
  logic [31:0] exp_q;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; writes must arrive only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_q  <= '0;
      bcast_q <= '1;
      mask_q  <= 8'd1;
      exp_q   <= 32'd30000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mrf_pkg::REG_SELF:  self_q  <= cfg_data_i;
        mrf_pkg::REG_BCAST: bcast_q <= cfg_data_i;
        mrf_pkg::REG_MASK:  mask_q  <= cfg_data_i[7:0];
        mrf_pkg::REG_EXP:   exp_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  logic           q_valid, q_ready;
  mrf_pkg::item_t q_item;

  mrf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .command_i, .sender_i, .receiver_i, .frame_type_i, .sequence_req_i,
    .ttl_i, .flags_i, .via_node_i, .now_tick_i,
    .self_addr_i(self_q), .bcast_addr_i(bcast_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  mrf_back #(.ROUTE_ENTRIES(ROUTE_ENTRIES), .SEEN_ENTRIES(SEEN_ENTRIES)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .mask_i(mask_q), .expiry_i(exp_q),
    .out_valid_o, .out_ready_i, .relay_o, .flood_o, .hop_addr_o,
    .out_ttl_o, .out_flags_o, .status_o, .purged_count_o
  );

endmodule

/* src/mrf_checker.sv */
// ----------------------------------------------------------------------------
// mrf_checker: port-level checks
// Watches the top level's result channel for consistent decisions.
// ----------------------------------------------------------------------------
module mrf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        relay_o,
  input logic        flood_o,
  input logic [63:0] hop_addr_o,
  input logic [2:0]  status_o,
  input logic [4:0]  purged_count_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result beat dropped while stalled");

  a_relay_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && relay_o |-> status_o == mrf_pkg::ST_OK && purged_count_o == 5'd0)
    else $error("relayed beat with bad status");

  a_flood_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flood_o |-> relay_o && hop_addr_o == 64'd0)
    else $error("flood beat with next hop");

endmodule

bind mesh_relay_forwarder_top mrf_checker u_mrf_checker (.*);

/* bench/mesh_relay_forwarder_top_tb.sv */
// ----------------------------------------------------------------------------
// mesh_relay_forwarder_top_tb: self-checking bench of the mesh relay forwarder
// Drives header beats and register writes, predicts every decision in a model
// of its own, and compares each result beat in order, under varied idling.
// ----------------------------------------------------------------------------
module mesh_relay_forwarder_top_tb;

  localparam int NROUTE = 16;
  localparam int NSEEN = 64;
  localparam int CYCLE_LIMIT = 400000;

  // A header beat as it goes into the block.
  typedef struct {
    logic [2:0]  command;
    logic [63:0] sender;
    logic [63:0] receiver;
    logic [7:0]  frame_type;
    logic [31:0] sequence_req;
    logic [7:0]  ttl;
    logic [7:0]  flags;
    logic [63:0] via_node;
    logic [31:0] now_tick;
  } header_t;

  // One relay decision as it comes out of the block.
  typedef struct packed {
    logic        relay;
    logic        flood;
    logic [63:0] hop_addr;
    logic [7:0]  out_ttl;
    logic [7:0]  out_flags;
    logic [2:0]  status;
    logic [4:0]  purged_count;
  } decision_t;

  // A directed row: the beat, and the decision when it is obvious.
  typedef struct {
    header_t   hdr;
    logic      typed;
    decision_t want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = '0;
  logic [63:0] sender_i = '0;
  logic [63:0] receiver_i = '0;
  logic [7:0]  frame_type_i = '0;
  logic [31:0] sequence_req_i = '0;
  logic [7:0]  ttl_i = '0;
  logic [7:0]  flags_i = '0;
  logic [63:0] via_node_i = '0;
  logic [31:0] now_tick_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        relay_o;
  logic        flood_o;
  logic [63:0] hop_addr_o;
  logic [7:0]  out_ttl_o;
  logic [7:0]  out_flags_o;
  logic [2:0]  status_o;
  logic [4:0]  purged_count_o;

  always #1 clk_i = ~clk_i;

  mesh_relay_forwarder_top u_dut (.*);

  // Predictor state: configuration and the two tables.
  logic [63:0] self_addr, bcast_addr;
  logic [7:0]  relay_mask;
  logic [31:0] expiry;
  logic        rt_valid [NROUTE];
  logic [63:0] rt_dest [NROUTE];
  logic [63:0] rt_via [NROUTE];
  logic [31:0] rt_seen [NROUTE];
  logic        dup_valid [NSEEN];
  logic [63:0] dup_sender [NSEEN];
  logic [39:0] dup_key [NSEEN];
  int          dup_wr;

  decision_t pending_decisions[$];
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int  n_frames = 0, n_tables = 0;

  // Sender pool, so duplicates, routes and own frames come up often.
  logic [63:0] addr_pool [8];

  // A decision with nothing but a status and a purge count.
  function automatic decision_t plain(logic [2:0] st, logic [4:0] pc = 5'd0);
    decision_t d;
    d = '0;
    d.status = st;
    d.purged_count = pc;
    return d;
  endfunction

  function automatic int route_lookup(logic [63:0] dst);
    for (int i = 0; i < NROUTE; i++)
      if (rt_valid[i] && rt_dest[i] == dst) return i;
    return -1;
  endfunction

  function automatic decision_t predict_decision(header_t h);
    decision_t d;
    logic [39:0] key;
    bit hit;
    int slot;
    int cnt;
    d = '0;
    key = {h.frame_type, h.sequence_req};
    hit = 1'b0;
    case (h.command)
      mrf_pkg::CMD_FORWARD, mrf_pkg::CMD_RELAY: begin
        for (int i = 0; i < NSEEN; i++)
          if (dup_valid[i] && dup_sender[i] == h.sender && dup_key[i] == key) hit = 1'b1;
        if (h.command == mrf_pkg::CMD_FORWARD &&
            (h.receiver == self_addr || h.receiver == bcast_addr))
          d.status = mrf_pkg::ST_FOR_ME;
        else if (h.sender == self_addr)
          d.status = mrf_pkg::ST_OWN;
        else if (h.ttl <= 8'd1)
          d.status = mrf_pkg::ST_HOP_LIMIT;
        else if (hit)
          d.status = mrf_pkg::ST_DUPLICATE;
        else begin
          dup_valid[dup_wr] = 1'b1;
          dup_sender[dup_wr] = h.sender;
          dup_key[dup_wr] = key;
          dup_wr = (dup_wr + 1) % NSEEN;
          d.relay = 1'b1;
          d.out_ttl = h.ttl - 8'd1;
          d.out_flags = h.flags | relay_mask;
          d.status = mrf_pkg::ST_OK;
          slot = (h.command == mrf_pkg::CMD_FORWARD) ? route_lookup(h.receiver) : -1;
          if (slot >= 0) d.hop_addr = rt_via[slot];
          else d.flood = 1'b1;
        end
      end
      mrf_pkg::CMD_LEARN: begin
        slot = route_lookup(h.receiver);
        if (slot < 0) begin
          for (int i = NROUTE - 1; i >= 0; i--)
            if (!rt_valid[i]) slot = i;
          if (slot < 0) d.status = mrf_pkg::ST_FULL;
          else begin
            rt_valid[slot] = 1'b1;
            rt_dest[slot] = h.receiver;
          end
        end
        if (slot >= 0) begin
          rt_via[slot] = h.via_node;
          rt_seen[slot] = h.now_tick;
        end
      end
      mrf_pkg::CMD_FORGET: begin
        slot = route_lookup(h.receiver);
        if (slot >= 0) rt_valid[slot] = 1'b0;
      end
      mrf_pkg::CMD_PURGE: begin
        cnt = 0;
        for (int i = 0; i < NROUTE; i++)
          if (rt_valid[i] && (h.now_tick - rt_seen[i]) > expiry) begin
            rt_valid[i] = 1'b0;
            if (cnt < 31) cnt++;
          end
        d.purged_count = cnt[4:0];
      end
      default: ;
    endcase
    return d;
  endfunction

  // Sender of header beats. The decision is predicted at acceptance. Valid
  // stays high after a beat so the next one can follow without a gap; it
  // drops only for idle cycles and before a drain.
  task automatic send_header(header_t h, bit typed = 1'b0, decision_t want = '0);
    decision_t d;
    bit idle;
    idle = (send_idle_pct > 0) && ($urandom_range(99) < send_idle_pct);
    if (idle) in_valid_i <= 1'b0;
    while (idle) begin
      @(posedge clk_i);
      idle = ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    command_i <= h.command;
    sender_i <= h.sender;
    receiver_i <= h.receiver;
    frame_type_i <= h.frame_type;
    sequence_req_i <= h.sequence_req;
    ttl_i <= h.ttl;
    flags_i <= h.flags;
    via_node_i <= h.via_node;
    now_tick_i <= h.now_tick;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    d = predict_decision(h);
    if (typed && d != want) begin
      errors++;
      if (errors <= 10)
        $display("typed row disagrees with predictor: status %0d vs %0d",
                 want.status, d.status);
    end
    pending_decisions.push_back(d);
    if (h.command <= mrf_pkg::CMD_RELAY) n_frames++; else n_tables++;
  endtask

  // Waits until the block has answered everything, plus a margin for the engine.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // Register write; the caller drops cfg_valid_i after the last one.
  task automatic write_register(logic [1:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      mrf_pkg::REG_SELF:  self_addr = val;
      mrf_pkg::REG_BCAST: bcast_addr = val;
      mrf_pkg::REG_MASK:  relay_mask = val[7:0];
      default:            expiry = val[31:0];
    endcase
  endtask

  function automatic header_t random_header();
    header_t h;
    int pick;
    h.command = ($urandom_range(99) < 3) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    pick = $urandom_range(99);
    if (pick < 60)
      h.command = ($urandom_range(3) != 0) ? mrf_pkg::CMD_FORWARD : mrf_pkg::CMD_RELAY;
    h.sender = ($urandom_range(3) != 0) ? addr_pool[$urandom_range(7)]
                                       : {$urandom, $urandom};
    h.receiver = ($urandom_range(3) != 0) ? addr_pool[$urandom_range(7)]
                                         : {$urandom, $urandom};
    h.frame_type = ($urandom_range(1) != 0) ? 8'($urandom_range(3)) : 8'($urandom);
    h.sequence_req = ($urandom_range(1) != 0) ? 32'($urandom_range(7)) : $urandom;
    h.ttl = ($urandom_range(9) == 0) ? 8'($urandom_range(1)) : 8'($urandom);
    h.flags = 8'($urandom);
    h.via_node = {$urandom, $urandom};
    h.now_tick = $urandom;
    return h;
  endfunction

  // Receiver: random stalls, plus a long hold-off asked by the stimulus.
  always @(posedge clk_i) begin
    out_ready_i <= !hold_recv && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  // Result checker: compares every accepted beat with the oldest prediction.
  always @(posedge clk_i) begin
    decision_t got, exp_d;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{relay_o, flood_o, hop_addr_o, out_ttl_o, out_flags_o, status_o, purged_count_o};
      if (pending_decisions.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat, status %0d", status_o);
      end else begin
        exp_d = pending_decisions.pop_front();
        checked++;
        if (got != exp_d) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp r%0b f%0b nh %h ttl %h fl %h st %0d pc %0d",
                     exp_d.relay, exp_d.flood, exp_d.hop_addr, exp_d.out_ttl,
                     exp_d.out_flags, exp_d.status, exp_d.purged_count);
            $display("          got r%0b f%0b nh %h ttl %h fl %h st %0d pc %0d",
                     got.relay, got.flood, got.hop_addr, got.out_ttl,
                     got.out_flags, got.status, got.purged_count);
          end
        end
      end
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    decision_t dz;
    header_t h;
    int n;
    self_addr = 64'd0;
    bcast_addr = '1;
    relay_mask = 8'd1;
    expiry = 32'd30000;
    dup_wr = 0;
    for (int i = 0; i < NROUTE; i++) rt_valid[i] = 1'b0;
    for (int i = 0; i < NSEEN; i++) dup_valid[i] = 1'b0;
    for (int i = 0; i < 8; i++) addr_pool[i] = {$urandom, $urandom};
    dz = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows, first at reset configuration; typed where plain.
    rows.push_back('{'{mrf_pkg::CMD_FORWARD, 64'h5, 64'h0, 8'h0, 32'h0, 8'h9, 8'h0, 64'h0,
                       32'h0}, 1'b1, plain(mrf_pkg::ST_FOR_ME)});
    rows.push_back('{'{mrf_pkg::CMD_FORWARD, 64'h5, '1, 8'hff, '1, 8'hff, 8'hff, '1, '1},
                   1'b1, plain(mrf_pkg::ST_FOR_ME)});
    rows.push_back('{'{mrf_pkg::CMD_RELAY, 64'h0, 64'h7, 8'h1, 32'h1, 8'h9, 8'h0, 64'h0,
                       32'h0}, 1'b1, plain(mrf_pkg::ST_OWN)});
    rows.push_back('{'{mrf_pkg::CMD_FORWARD, 64'h5, 64'h7, 8'h1, 32'h1, 8'h1, 8'h0, 64'h0,
                       32'h0}, 1'b1, plain(mrf_pkg::ST_HOP_LIMIT)});
    rows.push_back('{'{mrf_pkg::CMD_FORWARD, 64'h5, 64'h7, 8'h1, 32'h1, 8'h0, 8'h0, 64'h0,
                       32'h0}, 1'b1, plain(mrf_pkg::ST_HOP_LIMIT)});
    rows.push_back('{'{mrf_pkg::CMD_FORWARD, 64'h5, 64'h7, 8'h1, 32'h1, 8'hff, 8'h80, 64'h0,
                       32'h0}, 1'b1,
                     '{1'b1, 1'b1, 64'h0, 8'hfe, 8'h81, mrf_pkg::ST_OK, 5'd0}});
    rows.push_back('{'{mrf_pkg::CMD_FORWARD, 64'h5, 64'h7, 8'h1, 32'h1, 8'h2, 8'h0, 64'h0,
                       32'h0}, 1'b1, plain(mrf_pkg::ST_DUPLICATE)});
    rows.push_back('{'{mrf_pkg::CMD_LEARN, 64'h0, 64'h7, 8'h0, 32'h0, 8'h0, 8'h0, 64'hab,
                       32'hffff_fff0}, 1'b1, dz});
    rows.push_back('{'{mrf_pkg::CMD_FORWARD, 64'h5, 64'h7, 8'h2, 32'h1, 8'h2, 8'h0, 64'h0,
                       32'h0}, 1'b1,
                     '{1'b1, 1'b0, 64'hab, 8'h1, 8'h1, mrf_pkg::ST_OK, 5'd0}});
    rows.push_back('{'{mrf_pkg::CMD_RELAY, 64'h5, 64'h7, 8'h3, 32'h1, 8'h2, 8'h0, 64'h0,
                       32'h0}, 1'b1,
                     '{1'b1, 1'b1, 64'h0, 8'h1, 8'h1, mrf_pkg::ST_OK, 5'd0}});
    rows.push_back('{'{mrf_pkg::CMD_LEARN, 64'h0, 64'h7, 8'h0, 32'h0, 8'h0, 8'h0, 64'hcd,
                       32'h10}, 1'b0, dz});
    // Purge soon after the last learn: age is small, nothing goes.
    rows.push_back('{'{mrf_pkg::CMD_PURGE, 64'h0, 64'h0, 8'h0, 32'h0, 8'h0, 8'h0, 64'h0,
                       32'h20}, 1'b1, dz});
    rows.push_back('{'{mrf_pkg::CMD_FORGET, 64'h0, 64'h99, 8'h0, 32'h0, 8'h0, 8'h0, 64'h0,
                       32'h0}, 1'b1, dz});
    rows.push_back('{'{mrf_pkg::CMD_FORGET, 64'h0, 64'h7, 8'h0, 32'h0, 8'h0, 8'h0, 64'h0,
                       32'h0}, 1'b1, dz});
    rows.push_back('{'{3'd5, '1, '1, 8'hff, '1, 8'hff, 8'hff, '1, '1}, 1'b1, dz});
    rows.push_back('{'{3'd7, 64'h5, 64'h7, 8'h1, 32'h9, 8'h9, 8'h0, 64'h0, 32'h0}, 1'b1, dz});
    foreach (rows[i]) send_header(rows[i].hdr, rows[i].typed, rows[i].want);

    // Fill the route table, overflow it, then purge everything at once.
    for (int i = 0; i < NROUTE + 2; i++) begin
      h = '{mrf_pkg::CMD_LEARN, 64'h0, 64'(100 + i), 8'h0, 32'h0, 8'h0, 8'h0, 64'(i), 32'h0};
      if (i >= NROUTE) send_header(h, 1'b1, plain(mrf_pkg::ST_FULL));
      else send_header(h);
    end
    h = '{mrf_pkg::CMD_PURGE, 64'h0, 64'h0, 8'h0, 32'h0, 8'h0, 8'h0, 64'h0, 32'd30001};
    send_header(h, 1'b1, plain(mrf_pkg::ST_OK, 5'd16));
    drain_block();

    // Random phases, each under its own configuration and an idling mix.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        3: begin send_idle_pct = 23; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      write_register(mrf_pkg::REG_SELF, (phase == 4) ? '1 : addr_pool[phase]);
      write_register(mrf_pkg::REG_BCAST, (phase == 4) ? 64'd0 : addr_pool[7 - phase]);
      write_register(mrf_pkg::REG_MASK,
                     64'((phase == 1) ? 8'hff : (phase == 2) ? 8'h0 : 8'($urandom)));
      write_register(mrf_pkg::REG_EXP,
                     64'((phase == 2) ? 32'd0 : (phase == 3) ? '1 : $urandom_range(50000)));
      cfg_valid_i <= 1'b0;
      n = 100;
      for (int k = 0; k < n; k++) begin
        // One long receiver hold-off; the sender keeps offering meanwhile.
        if (phase == 0 && k == 20)
          fork begin
            hold_recv = 1'b1;
            repeat (2000) @(posedge clk_i);
            hold_recv = 1'b0;
          end join_none
        // Sender pauses for a complete drain once, mid phase.
        if (phase == 1 && k == 50) begin
          in_valid_i <= 1'b0;
          while (pending_decisions.size() != 0) @(posedge clk_i);
        end
        send_header(random_header());
      end
      drain_block();
    end

    $display("covered %0d frame beats and %0d table beats, %0d results checked",
             n_frames, n_tables, checked);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
src/mrf_pkg.sv
src/mrf_front.sv
src/mrf_back.sv
src/mesh_relay_forwarder_top.sv
src/mrf_checker.sv
bench/mesh_relay_forwarder_top_tb.sv
